[src/assert_macros.svh]
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion lbl failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion lbl failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[src/eae_pkg.sv]
package eae_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] CH_AT  = 8'h40;
    localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_US  = 8'h5F;

    typedef enum logic [1:0] {
        RS_IDLE     = 2'd0,
        RS_LOCAL    = 2'd1,
        RS_AFTER_AT = 2'd2,
        RS_DOMAIN   = 2'd3
    } t_rec_state;

    typedef enum logic [1:0] {
        CS_SCAN,
        CS_EMIT_REQ,
        CS_EMIT_LOAD
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic rd_req;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic terminate;
        logic rd_last;
        logic out_free;
    } t_dp_status;

    function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

endpackage

[src/eae_ram.sv]
module eae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/eae_ctrl.sv]
module eae_ctrl
    import eae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_SCAN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_SCAN: begin
                if (i_s_tvalid && i_status.terminate) begin
                    n_state = CS_EMIT_REQ;
                end
            end
            CS_EMIT_REQ: begin
                n_state = CS_EMIT_LOAD;
            end
            CS_EMIT_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.rd_last ? CS_SCAN : CS_EMIT_REQ;
                end
            end
            default: begin
                n_state = CS_SCAN;
            end
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.rd_req = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            CS_SCAN: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            CS_EMIT_REQ: begin
                o_cmd.rd_req = 1'b1;
            end
            CS_EMIT_LOAD: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

[src/eae_datapath.sv]
module eae_datapath
    import eae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_m_tready,
    output t_dp_status        o_status,
    output logic              o_m_tvalid,
    output logic [BYTE_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output logic              o_m_truncated
);

    t_rec_state        r_rec;
    t_rec_state        n_rec;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic              r_ovf;
    logic              n_ovf;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_data;
    logic              r_m_last;
    logic              r_m_trunc;

    logic              an;
    logic              do_append;
    logic              room;
    logic [LEN_W-1:0]  base_len;
    logic              base_ovf;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic              rd_last;
    logic              out_free;

    assign an       = is_alnum(i_s_tdata);
    assign base_len = (r_rec == RS_IDLE) ? '0 : r_len;
    assign base_ovf = (r_rec == RS_IDLE) ? 1'b0 : r_ovf;
    assign room     = base_len < LEN_W'(BUF_DEPTH);

    always_comb begin
        n_rec     = r_rec;
        do_append = 1'b1;
        unique case (r_rec)
            RS_IDLE: begin
                n_rec = an ? RS_LOCAL : RS_IDLE;
            end
            RS_LOCAL: begin
                if (i_s_tdata == CH_AT) begin
                    n_rec = RS_AFTER_AT;
                end else if (!(an || i_s_tdata == CH_DOT || i_s_tdata == CH_US)) begin
                    n_rec = RS_IDLE;
                end
            end
            RS_AFTER_AT: begin
                n_rec = an ? RS_DOMAIN : RS_IDLE;
            end
            RS_DOMAIN: begin
                if (!an && i_s_tdata == CH_DOT) begin
                    n_rec = RS_AFTER_AT;
                end else if (!an) begin
                    n_rec     = RS_IDLE;
                    do_append = 1'b0;
                end
            end
            default: begin
                n_rec = RS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (do_append) begin
            if (room) begin
                n_len = base_len + LEN_W'(1);
                n_ovf = base_ovf;
            end else begin
                n_len = base_len;
                n_ovf = 1'b1;
            end
        end
    end

    assign ram_we   = i_cmd.accept && do_append && room;
    assign rd_last  = LEN_W'(r_ptr) == (r_len - LEN_W'(1));
    assign out_free = !r_m_valid || i_m_tready;

    eae_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (base_len[ADDR_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (i_cmd.rd_req),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec     <= RS_IDLE;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_ptr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_rec <= n_rec;
                r_len <= n_len;
                r_ovf <= n_ovf;
            end
            if (i_cmd.load) begin
                r_ptr <= rd_last ? '0 : r_ptr + ADDR_W'(1);
            end
            if (i_cmd.load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m_data  <= ram_rdata;
            r_m_last  <= rd_last;
            r_m_trunc <= r_ovf;
        end
    end

    assign o_status.terminate = (r_rec == RS_DOMAIN) && !an && (i_s_tdata != CH_DOT);
    assign o_status.rd_last   = rd_last;
    assign o_status.out_free  = out_free;

    assign o_m_tvalid    = r_m_valid;
    assign o_m_tdata     = r_m_data;
    assign o_m_tlast     = r_m_last;
    assign o_m_truncated = r_m_trunc;

endmodule

[src/email_address_extractor.sv]
// Channel   Dir  tdata               tuser          tlast
// s         in   [7:0] text_byte     -              -
// m         out  [7:0] match_byte    [0] truncated  last_of_match
//
// Scanning takes one byte per cycle; the capture buffer is written as bytes arrive.
// A terminator starts emission: each address byte takes a buffer read, then an
// output register load; input held off until the last byte is loaded.
// A stall on m holds emission; the output register lets scanning resume under it.
// Reset (i_rst_n low, synchronous) returns the recogniser to idle; no clearing pass.
`include "assert_macros.svh"

module email_address_extractor
    import eae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] match_byte
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser    // [0] truncated
);

    t_dp_cmd    s_cmd;
    t_dp_status s_status;
    logic       s_trunc;

    eae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (s_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (s_cmd)
    );

    eae_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_s_tdata     (i_s_tdata),
        .i_m_tready    (i_m_tready),
        .o_status      (s_status),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_truncated (s_trunc)
    );

    assign o_m_tuser = s_trunc;

    `ASSERT_NEVER(a_load_busy, i_clk, i_rst_n, s_cmd.load && o_m_tvalid && !i_m_tready)
    `ASSERT_CLK(a_req_blocks_in, i_clk, i_rst_n, s_cmd.rd_req |=> !o_s_tready)
    `ASSERT_CLK(a_term_emits, i_clk, i_rst_n, (s_cmd.accept && s_status.terminate) |=> s_cmd.rd_req)

endmodule

[sim/tb_email_address_extractor.sv]
module tb_email_address_extractor
    import eae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_TAIL  = 2 * BUF_DEPTH + 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } t_match_beat;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;
    wire  [0:0] m_tuser;

    t_match_beat pending_addr_bytes[$];
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          active_bytes = 0;
    int          hold_request = 0;
    bit          send_idle    = 1'b1;
    bit          recv_idle    = 1'b1;

    t_rec_state  scan_state    = RS_IDLE;
    logic [7:0]  held_bytes[BUF_DEPTH];
    int          held_len      = 0;
    bit          held_overflow = 1'b0;

    email_address_extractor uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_word_char(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (held_len < BUF_DEPTH) begin
            held_bytes[held_len] = b;
            held_len++;
        end else begin
            held_overflow = 1'b1;
        end
    endfunction

    function automatic void recognise_byte(input logic [7:0] b);
        bit word;
        word = is_word_char(b);
        case (scan_state)
            RS_IDLE: begin
                held_len      = 0;
                held_overflow = 1'b0;
                hold_byte(b);
                scan_state = word ? RS_LOCAL : RS_IDLE;
            end
            RS_LOCAL: begin
                hold_byte(b);
                if (b == CH_AT)
                    scan_state = RS_AFTER_AT;
                else if (!(word || b == CH_DOT || b == CH_US))
                    scan_state = RS_IDLE;
            end
            RS_AFTER_AT: begin
                hold_byte(b);
                scan_state = word ? RS_DOMAIN : RS_IDLE;
            end
            default: begin
                if (word) begin
                    hold_byte(b);
                end else if (b == CH_DOT) begin
                    hold_byte(b);
                    scan_state = RS_AFTER_AT;
                end else begin
                    // drop the terminator, release the held address
                    for (int k = 0; k < held_len; k++)
                        pending_addr_bytes.push_back('{data:  held_bytes[k],
                                                       last:  (k == held_len - 1),
                                                       trunc: held_overflow});
                    scan_state = RS_IDLE;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_alnum();
        int idx;
        idx = $urandom_range(0, 61);
        if (idx < 10)
            return 8'(48 + idx);
        else if (idx < 36)
            return 8'(65 + idx - 10);
        else
            return 8'(97 + idx - 36);
    endfunction

    function automatic logic [7:0] rand_local_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return CH_DOT;
        else if (pick == 1)
            return CH_US;
        else
            return rand_alnum();
    endfunction

    function automatic logic [7:0] rand_other(input bit no_dot, input bit no_punct);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_word_char(b) || (no_dot && b == CH_DOT) ||
               (no_punct && (b == CH_US || b == CH_AT)));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (scan_state != RS_IDLE || is_word_char(b))
            active_bytes++;
        recognise_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_address(input int local_len, input int label_cnt,
                                input int label_len);
        send_byte(rand_alnum());
        repeat (local_len - 1) send_byte(rand_local_char());
        send_byte(CH_AT);
        for (int l = 0; l < label_cnt; l++) begin
            if (l != 0)
                send_byte(CH_DOT);
            repeat (label_len != 0 ? label_len : $urandom_range(1, 6))
                send_byte(rand_alnum());
        end
        send_byte(rand_other(1'b1, 1'b0));
    endtask

    task automatic send_broken_address();
        int variant;
        variant = $urandom_range(0, 2);
        send_byte(rand_alnum());
        repeat ($urandom_range(0, 5)) send_byte(rand_local_char());
        case (variant)
            0: begin
                send_byte(rand_other(1'b1, 1'b1));
            end
            1: begin
                send_byte(CH_AT);
                send_byte(rand_other(1'b0, 1'b0));
            end
            default: begin
                send_byte(CH_AT);
                send_byte(rand_alnum());
                send_byte(CH_DOT);
                send_byte(rand_other(1'b0, 1'b0));
            end
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_addr_bytes.size() != 0);
    endtask

    task automatic test_directed();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("a@b");
        send_byte(8'h00);
        send_text("Z_.9@");
        send_byte(8'h80);
        send_text("q@r.s");
        send_byte(8'h7F);
        send_text("k#x@y-");
    endtask

    task automatic test_long_addresses();
        send_address(60, 1, 3);
        send_address(61, 1, 3);
        send_address(60, 1, 9);
    endtask

    task automatic test_back_to_back();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (4) send_address($urandom_range(1, 8), $urandom_range(1, 3), 0);
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_request = HOLD_CYCLES;
        send_idle    = 1'b0;
        repeat (5) send_address($urandom_range(3, 8), 2, 0);
        send_idle = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_text();
        int start;
        int pick;
        start = active_bytes;
        while (active_bytes - start < 65) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_address($urandom_range(1, 8), $urandom_range(1, 3), 0);
            else if (pick == 7)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else
                send_broken_address();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial begin : result_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request != 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            stall = recv_idle ? $urandom_range(0, 11) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk) begin : check_results
        t_match_beat want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_addr_bytes.size() == 0) begin
                $display("%0t: unexpected transfer data=%h last=%b trunc=%b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
                mismatches++;
            end else begin
                want = pending_addr_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: match_byte expected %h actual %h",
                             $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_of_match expected %b actual %b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser[0] !== want.trunc) begin
                    $display("%0t: truncated expected %b actual %b",
                             $time, want.trunc, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_email_address_extractor: FAIL");
        $finish;
    end

    initial begin : run_tests
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_long_addresses();
        test_back_to_back();
        test_output_stall();
        test_random_text();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("tb_email_address_extractor: PASS");
        else
            $display("tb_email_address_extractor: FAIL");
        $finish;
    end

endmodule
